FILE: rtl/dsa_pkg.sv
`default_nettype none

package dsa_pkg;

  // Fixed field widths of the command and result ports.
  localparam int ENTRY_W     = 10;
  localparam int INDEX_W     = 17;
  localparam int CMD_W       = 3;
  localparam int FRAME_IN_W  = 2;
  localparam int COUNT_W     = 16;
  localparam int PCAP_W      = 11;
  localparam int TCAP_W      = 16;
  localparam int STRIDE_W    = 13;
  localparam int ADDR_W      = 64;
  localparam int PROD_W      = INDEX_W + STRIDE_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Reset values of the configuration registers.
  localparam logic [PCAP_W-1:0]   PCAP_RESET   = PCAP_W'(1024);
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC      = 3'd0,
    CMD_FREE       = 3'd1,
    CMD_RECLAIM    = 3'd2,
    CMD_ALLOC_TEMP = 3'd3,
    CMD_END_FRAME  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_BAD_FREE = 2'd2,
    ST_TEMP_OVF = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PERSISTENT_CAPACITY = 3'd0,
    CFG_TEMPORARY_CAPACITY  = 3'd1,
    CFG_SLOT_STRIDE         = 3'd2,
    CFG_CPU_BASE            = 3'd3,
    CFG_GPU_BASE            = 3'd4,
    CFG_SHADER_VISIBLE      = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_ADDR,
    S_RECLAIM
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/dsa_ram.sv
`default_nettype none

module dsa_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/dsa_addr_unit.sv
`default_nettype none

module dsa_addr_unit
  import dsa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire logic [INDEX_W-1:0]  index,
  input  wire logic [STRIDE_W-1:0] slot_stride,
  input  wire logic [ADDR_W-1:0]   cpu_base,
  input  wire logic [ADDR_W-1:0]   gpu_base,
  input  wire logic                shader_visible,
  output logic                     valid,
  output logic [INDEX_W-1:0]       index_out,
  output logic [ADDR_W-1:0]        cpu_address,
  output logic [ADDR_W-1:0]        gpu_address
);

  logic               prod_valid;
  logic [INDEX_W-1:0] prod_index;
  logic [PROD_W-1:0]  offset;

  // Control: one stage for the multiply, one for the base add.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      prod_valid <= load;
      valid      <= prod_valid;
    end
  end

  // Stage one: slot offset in bytes.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_index <= index;
      offset     <= PROD_W'(index) * PROD_W'(slot_stride);
    end
  end

  // Stage two: add the bases; an invisible heap gets a zero GPU address.
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      index_out   <= prod_index;
      cpu_address <= cpu_base + ADDR_W'(offset);
      gpu_address <= shader_visible ? gpu_base + ADDR_W'(offset) : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/descriptor_slot_allocator.sv
// Channel    | Ports                                               | Transaction
// -----------+-----------------------------------------------------+--------------------------
// command    | start, busy, command, slot_index, frame_slot,        | start high, busy low
//            | temp_count                                           |
// result     | done, result_index, cpu_address, gpu_address, status | done high for one cycle
// config     | cfg_write, cfg_index, cfg_data                       | cfg_write high
//
// Free, end frame, rejected commands and unknown commands return a registered status; a
// temporary allocate passes the address multiply, then the base add; an allocate passes
// the free-stack read, the multiply and the add; a reclaim reads one pending entry a cycle
// from the pending store and writes it back into the free stack.
// Synchronous reset; no clearing pass: stack entries at or above the high-water mark read
// as their own index. The result receiver cannot stall; each result is shown once.
`default_nettype none

module descriptor_slot_allocator
  import dsa_pkg::*;
#(
  parameter int SLOT_CAPACITY = 1024,
  parameter int FRAME_SLOTS   = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [CMD_W-1:0]       command,
  input  wire logic [ENTRY_W-1:0]     slot_index,
  input  wire logic [FRAME_IN_W-1:0]  frame_slot,
  input  wire logic [COUNT_W-1:0]     temp_count,
  output logic                        done,
  output logic [INDEX_W-1:0]          result_index,
  output logic [ADDR_W-1:0]           cpu_address,
  output logic [ADDR_W-1:0]           gpu_address,
  output logic [1:0]                  status,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int UW     = $clog2(SLOT_CAPACITY + 1);
  localparam int AW     = $clog2(SLOT_CAPACITY);
  localparam int FW     = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int PDEPTH = FRAME_SLOTS * SLOT_CAPACITY;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int TSUM_W = INDEX_W + 1;

  // Configuration registers.
  logic [PCAP_W-1:0]   persistent_capacity;
  logic [TCAP_W-1:0]   temporary_capacity;
  logic [STRIDE_W-1:0] slot_stride;
  logic [ADDR_W-1:0]   cpu_base;
  logic [ADDR_W-1:0]   gpu_base;
  logic                shader_visible;

  // Allocator state.
  state_t             state, state_next;
  logic [UW-1:0]      used_count, used_count_next;
  logic [UW-1:0]      high_mark, high_mark_next;
  logic [INDEX_W-1:0] temp_used, temp_used_next;
  logic [UW-1:0]      pending_length [FRAME_SLOTS];
  logic [UW-1:0]      pending_length_next [FRAME_SLOTS];
  logic [UW-1:0]      total_pending, total_pending_next;
  logic [FW-1:0]      rc_frame, rc_frame_next;
  logic [UW-1:0]      rc_len, rc_len_next;
  logic [UW-1:0]      rc_k, rc_k_next;
  logic               wb_valid, wb_valid_next;
  logic [AW-1:0]      wb_pos, wb_pos_next;
  logic               rd_ident, rd_ident_next;
  logic [ENTRY_W-1:0] rd_pos, rd_pos_next;
  logic               imm_done, imm_done_next;
  status_t            imm_status, imm_status_next;

  // Memory ports.
  logic               fs_we;
  logic [AW-1:0]      fs_waddr, fs_raddr;
  logic [ENTRY_W-1:0] fs_wdata, fs_rdata;
  logic               ps_we;
  logic [PAW-1:0]     ps_waddr, ps_raddr;
  logic [ENTRY_W-1:0] ps_rdata;

  // Address unit.
  logic               au_load;
  logic [INDEX_W-1:0] au_index;
  logic               au_valid;
  logic [INDEX_W-1:0] au_index_out;
  logic [ADDR_W-1:0]  au_cpu, au_gpu;

  // Command decode terms.
  logic               accept;
  logic               frame_ok;
  logic [FW-1:0]      frame_idx;
  logic [UW-1:0]      plen_sel;
  logic               stack_full;
  logic               free_bad;
  logic [TSUM_W-1:0]  temp_sum;
  logic               temp_bad;
  logic [TSUM_W-1:0]  temp_start;
  logic               rc_issue;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign frame_ok  = 32'(frame_slot) < FRAME_SLOTS;
  assign frame_idx = FW'(frame_slot);
  assign plen_sel  = frame_ok ? pending_length[frame_idx] : '0;

  // An allocate fails at the smaller of the register capacity and the stack depth.
  assign stack_full = (32'(used_count) >= 32'(persistent_capacity))
                   || (32'(used_count) >= SLOT_CAPACITY);

  assign free_bad = (32'(slot_index) >= 32'(persistent_capacity))
                 || (32'(slot_index) >= SLOT_CAPACITY)
                 || !frame_ok
                 || (total_pending >= used_count)
                 || (32'(plen_sel) >= SLOT_CAPACITY);

  assign temp_sum   = TSUM_W'(temp_used) + TSUM_W'(temp_count);
  assign temp_bad   = (temp_count == '0) || (temp_sum > TSUM_W'(temporary_capacity));
  assign temp_start = TSUM_W'(persistent_capacity) + TSUM_W'(temp_used);

  assign rc_issue = (rc_k < rc_len) && (used_count != '0);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      persistent_capacity <= PCAP_RESET;
      temporary_capacity  <= '0;
      slot_stride         <= STRIDE_RESET;
      cpu_base            <= '0;
      gpu_base            <= '0;
      shader_visible      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PERSISTENT_CAPACITY: persistent_capacity <= cfg_data[PCAP_W-1:0];
        CFG_TEMPORARY_CAPACITY:  temporary_capacity  <= cfg_data[TCAP_W-1:0];
        CFG_SLOT_STRIDE:         slot_stride         <= cfg_data[STRIDE_W-1:0];
        CFG_CPU_BASE:            cpu_base            <= cfg_data;
        CFG_GPU_BASE:            gpu_base            <= cfg_data;
        CFG_SHADER_VISIBLE:      shader_visible      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_ALLOC:      if (!stack_full) state_next = S_ALLOC;
            CMD_RECLAIM:    if (frame_ok) state_next = S_RECLAIM;
            CMD_ALLOC_TEMP: if (!temp_bad) state_next = S_ADDR;
            default: ;
          endcase
        end
      end
      S_ALLOC:   state_next = S_ADDR;
      S_ADDR:    state_next = S_IDLE;
      S_RECLAIM: if (!rc_issue) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Datapath controls and next values of the allocator state.
  always_comb begin
    used_count_next     = used_count;
    high_mark_next      = high_mark;
    temp_used_next      = temp_used;
    pending_length_next = pending_length;
    total_pending_next  = total_pending;
    rc_frame_next       = rc_frame;
    rc_len_next         = rc_len;
    rc_k_next           = rc_k;
    wb_valid_next       = 1'b0;
    wb_pos_next         = wb_pos;
    rd_ident_next       = rd_ident;
    rd_pos_next         = rd_pos;
    imm_done_next       = 1'b0;
    imm_status_next     = ST_OK;

    fs_we    = 1'b0;
    fs_waddr = wb_pos;
    fs_wdata = ps_rdata;
    fs_raddr = AW'(used_count);
    ps_we    = 1'b0;
    ps_waddr = PAW'(32'(frame_idx) * SLOT_CAPACITY + 32'(plen_sel));
    ps_raddr = PAW'(32'(rc_frame) * SLOT_CAPACITY + 32'(rc_k));
    au_load  = 1'b0;
    au_index = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_ALLOC: begin
              if (stack_full) begin
                imm_done_next   = 1'b1;
                imm_status_next = ST_NO_SLOT;
              end else begin
                // Pop: the read is in flight; entries never reached read as identity.
                used_count_next = used_count + 1'b1;
                rd_ident_next   = (used_count == high_mark);
                rd_pos_next     = ENTRY_W'(used_count);
                if (used_count == high_mark) begin
                  high_mark_next = high_mark + 1'b1;
                end
              end
            end
            CMD_FREE: begin
              imm_done_next = 1'b1;
              if (free_bad) begin
                imm_status_next = ST_BAD_FREE;
              end else begin
                ps_we                          = 1'b1;
                pending_length_next[frame_idx] = plen_sel + 1'b1;
                total_pending_next             = total_pending + 1'b1;
              end
            end
            CMD_RECLAIM: begin
              if (frame_ok) begin
                rc_frame_next                  = frame_idx;
                rc_len_next                    = plen_sel;
                rc_k_next                      = '0;
                pending_length_next[frame_idx] = '0;
                total_pending_next             = total_pending - plen_sel;
              end else begin
                imm_done_next = 1'b1;
              end
            end
            CMD_ALLOC_TEMP: begin
              if (temp_bad) begin
                imm_done_next   = 1'b1;
                imm_status_next = ST_TEMP_OVF;
              end else begin
                au_load        = 1'b1;
                au_index       = INDEX_W'(temp_start);
                temp_used_next = INDEX_W'(temp_sum);
              end
            end
            CMD_END_FRAME: begin
              imm_done_next  = 1'b1;
              temp_used_next = '0;
            end
            default: imm_done_next = 1'b1;
          endcase
        end
      end
      S_ALLOC: begin
        au_load  = 1'b1;
        au_index = INDEX_W'(rd_ident ? rd_pos : fs_rdata);
      end
      S_ADDR: ;
      S_RECLAIM: begin
        // Read one pending entry a cycle; write the previous one onto the stack.
        fs_we = wb_valid;
        if (rc_issue) begin
          rc_k_next       = rc_k + 1'b1;
          used_count_next = used_count - 1'b1;
          wb_valid_next   = 1'b1;
          wb_pos_next     = AW'(used_count - 1'b1);
        end else begin
          imm_done_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used_count    <= '0;
      high_mark     <= '0;
      temp_used     <= '0;
      total_pending <= '0;
      rc_frame      <= '0;
      rc_len        <= '0;
      rc_k          <= '0;
      wb_valid      <= 1'b0;
      rd_ident      <= 1'b0;
      imm_done      <= 1'b0;
      imm_status    <= ST_OK;
      for (int f = 0; f < FRAME_SLOTS; f++) begin
        pending_length[f] <= '0;
      end
    end else begin
      state          <= state_next;
      used_count     <= used_count_next;
      high_mark      <= high_mark_next;
      temp_used      <= temp_used_next;
      total_pending  <= total_pending_next;
      rc_frame       <= rc_frame_next;
      rc_len         <= rc_len_next;
      rc_k           <= rc_k_next;
      wb_valid       <= wb_valid_next;
      rd_ident       <= rd_ident_next;
      imm_done       <= imm_done_next;
      imm_status     <= imm_status_next;
      pending_length <= pending_length_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    wb_pos <= wb_pos_next;
    rd_pos <= rd_pos_next;
  end

  dsa_ram #(
    .DEPTH (SLOT_CAPACITY),
    .AW    (AW),
    .DW    (ENTRY_W)
  ) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  dsa_ram #(
    .DEPTH (PDEPTH),
    .AW    (PAW),
    .DW    (ENTRY_W)
  ) u_pending_store (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (slot_index),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  dsa_addr_unit u_addr_unit (
    .clk            (clk),
    .rst            (rst),
    .load           (au_load),
    .index          (au_index),
    .slot_stride    (slot_stride),
    .cpu_base       (cpu_base),
    .gpu_base       (gpu_base),
    .shader_visible (shader_visible),
    .valid          (au_valid),
    .index_out      (au_index_out),
    .cpu_address    (au_cpu),
    .gpu_address    (au_gpu)
  );

  // Result transaction: either an address result or an immediate status.
  assign done         = imm_done || au_valid;
  assign status       = au_valid ? ST_OK : imm_status;
  assign result_index = au_valid ? au_index_out : '0;
  assign cpu_address  = au_valid ? au_cpu : '0;
  assign gpu_address  = au_valid ? au_gpu : '0;

endmodule

`default_nettype wire
